// ===== sv/rapm_pkg.sv =====
package rapm_pkg;

    localparam int WINDOW_DEPTH = 600;
    localparam int PWM_BITS     = 10;

    localparam int SAMPLE_W = 24;
    localparam int BOUND_W  = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W    = $clog2(WINDOW_DEPTH);
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int KEY_W    = SAMPLE_W + 1;
    localparam int BIT_W    = $clog2(KEY_W);
    localparam int MAD_W    = KEY_W + 1;
    localparam int THR_W    = CFG_W + MAD_W;
    localparam int ACC_W    = CFG_W + 1 + BOUND_W;
    localparam int NUM_W    = BOUND_W + PWM_BITS + 1;
    localparam int DEN_W    = BOUND_W + 1;
    localparam int QI_W     = (PWM_BITS > 1) ? $clog2(PWM_BITS) : 1;

    localparam logic [PWM_BITS-1:0]  PWM_FULL    = {PWM_BITS{1'b1}};
    localparam logic [BOUND_W-1:0]   ONE_LUX     = 32'd4096;
    localparam logic [BOUND_W-1:0]   HIGH_RESET  = 32'd4096000;
    localparam logic [CFG_W-1:0]     ALPHA_RESET = 16'd3277;
    localparam logic [CFG_W-1:0]     SCALE_RESET = 16'd18218;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd1;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd2;
    localparam logic [OP_W-1:0] OP_SEL_INIT   = 4'd3;
    localparam logic [OP_W-1:0] OP_SCAN_START = 4'd4;
    localparam logic [OP_W-1:0] OP_SCAN       = 4'd5;
    localparam logic [OP_W-1:0] OP_SEL_BIT    = 4'd6;
    localparam logic [OP_W-1:0] OP_SAVE_A     = 4'd7;
    localparam logic [OP_W-1:0] OP_CENTER     = 4'd8;
    localparam logic [OP_W-1:0] OP_THR        = 4'd9;
    localparam logic [OP_W-1:0] OP_BL_MUL     = 4'd10;
    localparam logic [OP_W-1:0] OP_BL_ADD     = 4'd11;
    localparam logic [OP_W-1:0] OP_FIX        = 4'd12;
    localparam logic [OP_W-1:0] OP_MAP        = 4'd13;
    localparam logic [OP_W-1:0] OP_DIV        = 4'd14;
    localparam logic [OP_W-1:0] OP_OUT        = 4'd15;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                led_enable;
    } in_t;

    typedef struct packed {
        logic [PWM_BITS-1:0] pwm_level;
        logic [SAMPLE_W-1:0] low_bound;
        logic [SAMPLE_W-1:0] high_bound;
    } out_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            dev;
        logic            lo;
        logic            inlier;
        logic            hi;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic bit_zero;
        logic cnt_odd;
        logic div_last;
        logic out_busy;
    } status_t;

endpackage

// ===== sv/rapm_ctrl.sv =====
module rapm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rapm_pkg::status_t status,
    output rapm_pkg::cmd_t   cmd
);
    import rapm_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_WRITE  = 5'd1;
    localparam logic [4:0] S_SINIT  = 5'd2;
    localparam logic [4:0] S_SSTART = 5'd3;
    localparam logic [4:0] S_SCAN   = 5'd4;
    localparam logic [4:0] S_SBIT   = 5'd5;
    localparam logic [4:0] S_SAVE   = 5'd6;
    localparam logic [4:0] S_CENTER = 5'd7;
    localparam logic [4:0] S_THR    = 5'd8;
    localparam logic [4:0] S_ISTART = 5'd9;
    localparam logic [4:0] S_ISCAN  = 5'd10;
    localparam logic [4:0] S_BLM_L  = 5'd11;
    localparam logic [4:0] S_BLA_L  = 5'd12;
    localparam logic [4:0] S_BLM_H  = 5'd13;
    localparam logic [4:0] S_BLA_H  = 5'd14;
    localparam logic [4:0] S_FIX    = 5'd15;
    localparam logic [4:0] S_MAP    = 5'd16;
    localparam logic [4:0] S_DIV    = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0] state_reg, state_next;
    logic       dev_reg, dev_next;
    logic       lo_reg, lo_next;

    always_comb
    begin
        state_next = state_reg;
        dev_next   = dev_reg;
        lo_next    = lo_reg;
        cmd.op     = OP_NOP;
        cmd.dev    = dev_reg;
        cmd.lo     = lo_reg;
        cmd.inlier = 1'b0;
        cmd.hi     = 1'b0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.op     = OP_WRITE;
                dev_next   = 1'b0;
                lo_next    = 1'b0;
                state_next = S_SINIT;
            end
            S_SINIT:
            begin
                cmd.op     = OP_SEL_INIT;
                state_next = S_SSTART;
            end
            S_SSTART:
            begin
                cmd.op     = OP_SCAN_START;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (status.scan_done)
                begin
                    state_next = S_SBIT;
                end
            end
            S_SBIT:
            begin
                cmd.op     = OP_SEL_BIT;
                state_next = status.bit_zero ? S_SAVE : S_SSTART;
            end
            S_SAVE:
            begin
                if (lo_reg)
                begin
                    state_next = S_CENTER;
                end
                else
                begin
                    cmd.op = OP_SAVE_A;
                    if (status.cnt_odd)
                    begin
                        state_next = S_CENTER;
                    end
                    else
                    begin
                        lo_next    = 1'b1;
                        state_next = S_SINIT;
                    end
                end
            end
            S_CENTER:
            begin
                cmd.op = OP_CENTER;
                if (dev_reg)
                begin
                    state_next = S_THR;
                end
                else
                begin
                    dev_next   = 1'b1;
                    lo_next    = 1'b0;
                    state_next = S_SINIT;
                end
            end
            S_THR:
            begin
                cmd.op     = OP_THR;
                state_next = S_ISTART;
            end
            S_ISTART:
            begin
                cmd.op     = OP_SCAN_START;
                state_next = S_ISCAN;
            end
            S_ISCAN:
            begin
                cmd.op     = OP_SCAN;
                cmd.inlier = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_BLM_L;
                end
            end
            S_BLM_L:
            begin
                cmd.op     = OP_BL_MUL;
                state_next = S_BLA_L;
            end
            S_BLA_L:
            begin
                cmd.op     = OP_BL_ADD;
                state_next = S_BLM_H;
            end
            S_BLM_H:
            begin
                cmd.op     = OP_BL_MUL;
                cmd.hi     = 1'b1;
                state_next = S_BLA_H;
            end
            S_BLA_H:
            begin
                cmd.op     = OP_BL_ADD;
                cmd.hi     = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.op     = OP_FIX;
                state_next = S_MAP;
            end
            S_MAP:
            begin
                cmd.op     = OP_MAP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dev_reg   <= 1'b0;
            lo_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dev_reg   <= dev_next;
            lo_reg    <= lo_next;
        end
    end

endmodule

// ===== sv/rapm_dp.sv =====
module rapm_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rapm_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output rapm_pkg::out_t                     out_data,
    input  logic                               cfg_wr_en,
    input  logic [rapm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rapm_pkg::CFG_W-1:0]         cfg_data,
    input  rapm_pkg::cmd_t                     cmd,
    output rapm_pkg::status_t                  status
);
    import rapm_pkg::*;

    logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    addr_reg, addr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    kth_reg, kth_next;
    logic [KEY_W-1:0]    prefix_reg, prefix_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [KEY_W-1:0]    sel_a_reg, sel_a_next;
    logic [KEY_W-1:0]    med2_reg, med2_next;
    logic [MAD_W-1:0]    mad4_reg, mad4_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic                any_reg, any_next;
    logic [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;
    logic [CFG_W-1:0]    alpha_reg, alpha_next;
    logic [CFG_W-1:0]    scale_reg, scale_next;
    logic [BOUND_W-1:0]  low_reg, low_next;
    logic [BOUND_W-1:0]  high_reg, high_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                led_reg, led_next;
    logic                zero_reg, zero_next;
    logic                full_reg, full_next;
    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [PWM_BITS-1:0] q_reg, q_next;
    logic [QI_W-1:0]     qi_reg, qi_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_reg, out_next;

    logic [KEY_W-1:0]    s2;
    logic [KEY_W-1:0]    dev;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    hi_mask;
    logic                match;
    logic                ok;
    logic [BOUND_W-1:0]  target;
    logic [BOUND_W-1:0]  old_bound;
    logic [ACC_W-1:0]    sum;
    logic [BOUND_W-1:0]  x;
    logic [BOUND_W-1:0]  span;
    logic [DEN_W-1:0]    lift;
    logic [NUM_W-1:0]    trial;
    logic                issue;

    assign issue = (cmd.op == OP_SCAN) && (addr_reg != count_reg);

    always_comb
    begin
        s2        = {rd_data_reg, 1'b0};
        dev       = (s2 >= med2_reg) ? (s2 - med2_reg) : (med2_reg - s2);
        key       = cmd.dev ? dev : {1'b0, rd_data_reg};
        hi_mask   = ({KEY_W{1'b1}} << bit_reg) << 1;
        match     = (((key ^ prefix_reg) & hi_mask) == '0) && !key[bit_reg];
        ok        = (mad4_reg == '0) || (THR_W'({dev, 13'b0}) <= thr_reg);
        old_bound = cmd.hi ? high_reg : low_reg;
        if (any_reg)
        begin
            target = cmd.hi ? {max_reg, 8'b0} : {min_reg, 8'b0};
        end
        else
        begin
            target = {med2_reg, 7'b0};
        end
        sum   = acc_reg + ACC_W'(alpha_reg) * ACC_W'(target) + ACC_W'(32'd32768);
        x     = {sample_reg, 8'b0};
        span  = high_reg - low_reg;
        lift  = {1'b0, low_reg} + DEN_W'(ONE_LUX);
        trial = NUM_W'(den_reg) << qi_reg;
    end

    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        rd_vld_next    = rd_vld_reg;
        cnt_next       = cnt_reg;
        kth_next       = kth_reg;
        prefix_next    = prefix_reg;
        bit_next       = bit_reg;
        sel_a_next     = sel_a_reg;
        med2_next      = med2_reg;
        mad4_next      = mad4_reg;
        thr_next       = thr_reg;
        any_next       = any_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        alpha_next     = alpha_reg;
        scale_next     = scale_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        acc_next       = acc_reg;
        sample_next    = sample_reg;
        led_next       = led_reg;
        zero_next      = zero_reg;
        full_next      = full_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        q_next         = q_reg;
        qi_next        = qi_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ALPHA: alpha_next = cfg_data;
                REG_SCALE: scale_next = cfg_data;
                default:   ;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                sample_next = in_data.sample;
                led_next    = in_data.led_enable;
            end
            OP_WRITE:
            begin
                wr_idx_next = (wr_idx_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
                if (count_reg != CNT_W'(WINDOW_DEPTH))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_SEL_INIT:
            begin
                prefix_next = '0;
                bit_next    = BIT_W'(KEY_W - 1);
                kth_next    = (count_reg >> 1) - CNT_W'(cmd.lo);
            end
            OP_SCAN_START:
            begin
                addr_next   = '0;
                cnt_next    = '0;
                any_next    = 1'b0;
                rd_vld_next = 1'b0;
            end
            OP_SCAN:
            begin
                rd_vld_next = issue;
                if (issue)
                begin
                    addr_next = addr_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (cmd.inlier)
                    begin
                        if (ok)
                        begin
                            any_next = 1'b1;
                            if (!any_reg || rd_data_reg < min_reg)
                            begin
                                min_next = rd_data_reg;
                            end
                            if (!any_reg || rd_data_reg > max_reg)
                            begin
                                max_next = rd_data_reg;
                            end
                        end
                    end
                    else if (match)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            OP_SEL_BIT:
            begin
                if (kth_reg >= cnt_reg)
                begin
                    prefix_next[bit_reg] = 1'b1;
                    kth_next             = kth_reg - cnt_reg;
                end
                if (bit_reg != '0)
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            OP_SAVE_A:
            begin
                sel_a_next = prefix_reg;
            end
            OP_CENTER:
            begin
                if (cmd.dev)
                begin
                    mad4_next = count_reg[0] ? {sel_a_reg, 1'b0}
                                             : MAD_W'(sel_a_reg) + MAD_W'(prefix_reg);
                end
                else
                begin
                    med2_next = count_reg[0] ? {sel_a_reg[KEY_W-2:0], 1'b0}
                                             : sel_a_reg + prefix_reg;
                end
            end
            OP_THR:
            begin
                thr_next = THR_W'(scale_reg) * THR_W'(mad4_reg);
            end
            OP_BL_MUL:
            begin
                acc_next = ACC_W'({1'b1, {CFG_W{1'b0}}} - {1'b0, alpha_reg}) * ACC_W'(old_bound);
            end
            OP_BL_ADD:
            begin
                if (cmd.hi)
                begin
                    high_next = sum[CFG_W +: BOUND_W];
                end
                else
                begin
                    low_next = sum[CFG_W +: BOUND_W];
                end
            end
            OP_FIX:
            begin
                if (high_reg <= low_reg)
                begin
                    high_next = lift[BOUND_W] ? {BOUND_W{1'b1}} : lift[BOUND_W-1:0];
                end
            end
            OP_MAP:
            begin
                zero_next = (x <= low_reg);
                full_next = (x >= high_reg);
                rem_next  = NUM_W'(x - low_reg) * NUM_W'({PWM_FULL, 1'b0}) + NUM_W'(span);
                den_next  = {span, 1'b0};
                q_next    = '0;
                qi_next   = QI_W'(PWM_BITS - 1);
            end
            OP_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next      = rem_reg - trial;
                    q_next[qi_reg] = 1'b1;
                end
                if (qi_reg != '0)
                begin
                    qi_next = qi_reg - 1'b1;
                end
            end
            OP_OUT:
            begin
                out_valid_next     = 1'b1;
                out_next.low_bound  = low_reg[BOUND_W-1:8];
                out_next.high_bound = high_reg[BOUND_W-1:8];
                if (!led_reg || zero_reg)
                begin
                    out_next.pwm_level = '0;
                end
                else if (full_reg)
                begin
                    out_next.pwm_level = PWM_FULL;
                end
                else
                begin
                    out_next.pwm_level = q_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE)
        begin
            ring[wr_idx_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= ring[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            alpha_reg     <= ALPHA_RESET;
            scale_reg     <= SCALE_RESET;
            low_reg       <= '0;
            high_reg      <= HIGH_RESET;
            bit_reg       <= '0;
            qi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_idx_reg    <= wr_idx_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            rd_vld_reg    <= rd_vld_next;
            alpha_reg     <= alpha_next;
            scale_reg     <= scale_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            bit_reg       <= bit_next;
            qi_reg        <= qi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        kth_reg    <= kth_next;
        prefix_reg <= prefix_next;
        sel_a_reg  <= sel_a_next;
        med2_reg   <= med2_next;
        mad4_reg   <= mad4_next;
        thr_reg    <= thr_next;
        any_reg    <= any_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
        led_reg    <= led_next;
        zero_reg   <= zero_next;
        full_reg   <= full_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        q_reg      <= q_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign status.scan_done = (addr_reg == count_reg) && !rd_vld_reg;
    assign status.bit_zero  = (bit_reg == '0);
    assign status.cnt_odd   = count_reg[0];
    assign status.div_last  = (qi_reg == '0);
    assign status.out_busy  = out_valid_reg && out_stall;

endmodule

// ===== sv/robust_autorange_pwm_mapper.sv =====
// Channel   Handshake             Payload
// -------   -------------------   ----------------------------------------
// in        in_valid / in_stall   in_data   : sample, led_enable
// out       out_valid / out_stall out_data  : pwm_level, low_bound, high_bound
// cfg       cfg_wr_en             cfg_index, cfg_data (no wait, no read-back)
//
// An item takes S radix selection runs, n the window fill (up to 600): S = 2 when
// n is odd, 4 when even; each selection makes 25 passes over the single-read-port
// sample window.
// Reset restores bounds and registers; window contents are not cleared.
// Input stalls while an item is in work; a finished result waits in the
// output register and the next item may be taken meanwhile.
module robust_autorange_pwm_mapper (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  rapm_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output rapm_pkg::out_t                 out_data,
    input  logic                           cfg_wr_en,
    input  logic [rapm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rapm_pkg::CFG_W-1:0]     cfg_data
);
    import rapm_pkg::*;

    cmd_t    cmd;
    status_t status;

    rapm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rapm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |-> in_valid && !in_stall)
        else $error("sample loaded without transfer");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.high_bound >= out_data.low_bound)
        else $error("high bound below low bound");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rapm_pkg::*;

    localparam longint CYCLE_LIMIT = 8000000;

    class bounds_scoreboard;
        logic [SAMPLE_W-1:0] window_q[$];
        logic [BOUND_W-1:0]  low_q12;
        logic [BOUND_W-1:0]  high_q12;
        logic [CFG_W-1:0]    alpha;
        logic [CFG_W-1:0]    scale;
        out_t                pending_q[$];

        function new();
            low_q12  = '0;
            high_q12 = HIGH_RESET;
            alpha    = ALPHA_RESET;
            scale    = SCALE_RESET;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_ALPHA)
                alpha = val;
            else if (idx == REG_SCALE)
                scale = val;
        endfunction

        function longint unsigned twice_median(longint unsigned vals[$]);
            longint unsigned srt[$];
            int              n;
            srt = vals;
            srt.sort();
            n = srt.size();
            if (n % 2)
                return 2 * srt[n/2];
            return srt[n/2-1] + srt[n/2];
        endfunction

        function logic [BOUND_W-1:0] blend(logic [BOUND_W-1:0] old_v,
                                           logic [BOUND_W-1:0] target);
            longint unsigned acc;
            acc = (longint'(65536) - alpha) * old_v + longint'(alpha) * target + 32768;
            return acc[47:16];
        endfunction

        function void note(in_t item);
            longint unsigned samples[$];
            longint unsigned devs[$];
            longint unsigned med2, mad4, x, span, pwm, hsum;
            longint unsigned in_min, in_max;
            logic [BOUND_W-1:0] t_low, t_high;
            int   in_count;
            out_t res;
            window_q.push_back(item.sample);
            if (window_q.size() > WINDOW_DEPTH)
                void'(window_q.pop_front());
            foreach (window_q[i])
                samples.push_back(window_q[i]);
            med2 = twice_median(samples);
            foreach (samples[i])
                devs.push_back(2*samples[i] >= med2 ? 2*samples[i] - med2
                                                    : med2 - 2*samples[i]);
            mad4 = twice_median(devs);
            in_count = 0;
            in_min = 0;
            in_max = 0;
            foreach (samples[i])
            begin
                if (mad4 == 0 || devs[i] * 8192 <= longint'(scale) * mad4)
                begin
                    if (in_count == 0 || samples[i] < in_min)
                        in_min = samples[i];
                    if (in_count == 0 || samples[i] > in_max)
                        in_max = samples[i];
                    in_count++;
                end
            end
            if (in_count == 0)
            begin
                t_low  = BOUND_W'(med2 << 7);
                t_high = t_low;
            end
            else
            begin
                t_low  = BOUND_W'(in_min << 8);
                t_high = BOUND_W'(in_max << 8);
            end
            low_q12  = blend(low_q12, t_low);
            high_q12 = blend(high_q12, t_high);
            if (high_q12 <= low_q12)
            begin
                hsum = longint'(low_q12) + ONE_LUX;
                high_q12 = hsum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : hsum[31:0];
            end
            x = longint'(item.sample) << 8;
            if (x <= low_q12)
                pwm = 0;
            else if (x >= high_q12)
                pwm = PWM_FULL;
            else
            begin
                span = high_q12 - low_q12;
                pwm = ((x - low_q12) * PWM_FULL * 2 + span) / (2 * span);
                if (pwm > PWM_FULL)
                    pwm = PWM_FULL;
            end
            if (!item.led_enable)
                pwm = 0;
            res.pwm_level  = pwm[PWM_BITS-1:0];
            res.low_bound  = low_q12[31:8];
            res.high_bound = high_q12[31:8];
            pending_q.push_back(res);
        endfunction

        // -1: nothing expected; else bit 0 pwm, bit 1 low, bit 2 high mismatch
        function int check(out_t got, output out_t want);
            int bad;
            want = '0;
            if (pending_q.size() == 0)
                return -1;
            want = pending_q.pop_front();
            bad = 0;
            if (got.pwm_level !== want.pwm_level)
                bad |= 1;
            if (got.low_bound !== want.low_bound)
                bad |= 2;
            if (got.high_bound !== want.high_bound)
                bad |= 4;
            return bad;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bounds_scoreboard sb;
    int     errors;
    int     transfers;
    longint cycles;
    bit     calm;
    bit     hold_req;
    bit     holding;

    robust_autorange_pwm_mapper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
    endtask

    always @(posedge clk)
    begin
        out_t want;
        int   bad;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            sb.note(in_data);
            transfers++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            bad = sb.check(out_data, want);
            if (bad < 0)
                report("unexpected result", out_data.pwm_level, 0);
            else
            begin
                if (bad & 1)
                    report("pwm_level", out_data.pwm_level, want.pwm_level);
                if (bad & 2)
                    report("low_bound", out_data.low_bound, want.low_bound);
                if (bad & 4)
                    report("high_bound", out_data.high_bound, want.high_bound);
            end
        end
    end

    always @(negedge clk)
    begin
        if (holding)
            out_stall = 1'b1;
        else if (calm)
            out_stall = 1'b0;
        else
            out_stall = ($urandom_range(99) < 20);
    end

    // long receiver hold-off
    initial
    begin
        holding = 1'b0;
        wait (hold_req);
        @(negedge clk);
        holding = 1'b1;
        repeat (30000) @(negedge clk);
        holding = 1'b0;
    end

    task automatic send(logic [SAMPLE_W-1:0] s, logic led);
        if (!calm)
        begin
            while ($urandom_range(99) < 20)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        in_data.sample = s;
        in_data.led_enable = led;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample(logic [SAMPLE_W-1:0] base);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return SAMPLE_W'($urandom_range(32'hFF_FFFF));
        if (r < 15)
            return $urandom_range(1) ? 24'hFF_FFFF : 24'h0;
        return SAMPLE_W'(base + $urandom_range(4000) - 2000);
    endfunction

    task automatic random_phase(int count);
        logic [SAMPLE_W-1:0] base;
        base = SAMPLE_W'($urandom_range(24'hF0_0000, 24'h1000));
        for (int i = 0; i < count; i++)
            send(rand_sample(base), $urandom_range(99) < 85);
    endtask

    initial
    begin
        sb = new();
        errors = 0;
        transfers = 0;
        cycles = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(24'h0, 1'b1);
        send(24'hFF_FFFF, 1'b1);
        send(24'hFF_FFFF, 1'b0);
        send(24'h0, 1'b0);
        send(24'h00_3E80, 1'b1);
        send(24'h00_3E80, 1'b1);
        send(24'h00_3E80, 1'b1);
        send(24'h00_3E81, 1'b1);
        send(24'hAA_AAAA, 1'b1);
        send(24'h55_5555, 1'b1);

        cfg_write(REG_ALPHA, 16'hFFFF);
        cfg_write(REG_SCALE, 16'hFFFF);
        send(24'hFF_FFFF, 1'b1);
        send(24'hFF_FFFF, 1'b1);
        send(24'hFF_FFFF, 1'b1);
        send(24'hFF_FFFF, 1'b1);
        send(24'h0, 1'b1);

        cfg_write(REG_ALPHA, 16'h0000);
        cfg_write(REG_SCALE, 16'h0000);
        send(24'h00_1000, 1'b1);
        send(24'h80_0000, 1'b1);
        send(24'h00_0001, 1'b1);

        cfg_write(REG_ALPHA, 16'h8000);
        cfg_write(REG_SCALE, 16'h0001);
        send(24'h12_3456, 1'b1);
        send(24'h12_3400, 1'b1);
        send(24'h00_0010, 1'b1);

        cfg_write(REG_ALPHA, ALPHA_RESET);
        cfg_write(REG_SCALE, SCALE_RESET);
        random_phase(25);

        calm = 1'b1;
        hold_req = 1'b1;
        random_phase(20);
        calm = 1'b0;

        drain();
        random_phase(15);

        for (int p = 0; p < 4; p++)
        begin
            cfg_write(REG_ALPHA, CFG_W'($urandom_range(16'hFFFF)));
            cfg_write(REG_SCALE, CFG_W'($urandom_range(p == 0 ? 16'h2000 : 16'hFFFF)));
            random_phase(14);
        end

        drain();
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
